### rtl/swmt_pkg.sv
//------------------------------------------------------------------------------
// swmt_pkg
// Shared types and constants of the sliding window mode tracker.
//------------------------------------------------------------------------------
`default_nettype none

package swmt_pkg;

  localparam int NumBinsDef     = 64;
  localparam int WindowDepthDef = 256;
  localparam int CountBitsDef   = 16;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxBits-1:0] REG_RANGE_MIN   = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_RANGE_MAX   = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_BIN_SCALE   = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_BIN_WIDTH   = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_ALPHA       = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_BINS_IN_USE = 3'd5;
  localparam logic [CfgIdxBits-1:0] REG_WINDOW_LEN  = 3'd6;

  localparam logic signed [23:0] Q24Max = 24'sh7FFFFF;
  localparam logic signed [23:0] Q24Min = -24'sh800000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_WREAD,
    ST_OLD,
    ST_DEC,
    ST_SCAN,
    ST_NEWRD,
    ST_NEW,
    ST_MODEV,
    ST_EMA,
    ST_OUT
  } state_t;

  // Saturate a wide signed value to 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) r = Q24Max;
    else if (v < -48'sd8388608) r = Q24Min;
    else r = v[23:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/swmt_ram.sv
//------------------------------------------------------------------------------
// swmt_ram
// Generic single-port-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module swmt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AddrBits-1:0] waddr,
  input  wire logic [Width-1:0]    wdata,
  input  wire logic [AddrBits-1:0] raddr,
  output logic      [Width-1:0]    rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/sliding_window_mode_tracker_core.sv
//------------------------------------------------------------------------------
// sliding_window_mode_tracker_core
// Histogram mode tracker over a sliding window of binned samples, with EMA.
// Sequence: a rejected word goes straight to its result. An accepted word is
// binned; with a window, the leaving entry is read, replaced and its bin count
// decremented, and the bin counts in use are rescanned when the leaving bin
// was the mode; then the new bin is counted, the mode value and EMA are updated
// and the result is registered. Flow: one word at a time; the next word is
// taken only once out_ready has taken the result. Reset: synchronous rst_n;
// afterwards a clearing pass zeroes both RAMs before the first word is taken.
//------------------------------------------------------------------------------
`default_nettype none

module sliding_window_mode_tracker_core
  import swmt_pkg::*;
#(
  parameter int NUM_BINS     = NumBinsDef,
  parameter int WINDOW_DEPTH = WindowDepthDef,
  parameter int COUNT_BITS   = CountBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [15:0]     in_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [23:0]          out_smoothed_value,
  output logic        [5:0]           out_mode_bin,
  output logic        [15:0]          out_mode_count,
  output logic                        out_accepted,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxBits-1:0]  cfg_index,
  input  wire logic [CfgDataBits-1:0] cfg_data
);

  localparam int BinBits = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int BinCntW = $clog2(NUM_BINS + 1);
  localparam int WinBits = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WinCntW = $clog2(WINDOW_DEPTH + 1);
  localparam int ClrMax  = (NUM_BINS > WINDOW_DEPTH) ? NUM_BINS : WINDOW_DEPTH;
  localparam int ClrW    = $clog2(ClrMax + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // Configuration registers.
  logic signed [15:0] range_min_r, range_max_r;
  logic [31:0] bin_scale_r;
  logic [15:0] bin_width_r;
  logic [16:0] alpha_r;
  logic [6:0]  bins_in_use_r;
  logic [8:0]  window_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r   <= 16'sd0;
      range_max_r   <= 16'sd32767;
      bin_scale_r   <= 32'd65536;
      bin_width_r   <= 16'd256;
      alpha_r       <= 17'd6554;
      bins_in_use_r <= 7'd64;
      window_len_r  <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN:   range_min_r   <= cfg_data[15:0];
        REG_RANGE_MAX:   range_max_r   <= cfg_data[15:0];
        REG_BIN_SCALE:   bin_scale_r   <= cfg_data[31:0];
        REG_BIN_WIDTH:   bin_width_r   <= cfg_data[15:0];
        REG_ALPHA:       alpha_r       <= cfg_data[16:0];
        REG_BINS_IN_USE: bins_in_use_r <= cfg_data[6:0];
        REG_WINDOW_LEN:  window_len_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Effective register values: bin and window counts clamped to the configured storage, alpha to 65536.
  logic [BinCntW-1:0] nbins;
  logic [WinCntW-1:0] wlen;
  logic [16:0]        alpha_eff;
  always_comb begin
    nbins = (32'(bins_in_use_r) > NUM_BINS) ? BinCntW'(NUM_BINS)
                                             : BinCntW'(bins_in_use_r);
    wlen = (32'(window_len_r) > WINDOW_DEPTH) ? WinCntW'(WINDOW_DEPTH)
                                               : WinCntW'(window_len_r);
    alpha_eff = (alpha_r > 17'd65536) ? 17'd65536 : alpha_r;
  end

  // State registers.
  state_t state_r, state_nxt;
  logic [ClrW-1:0]       clr_r;
  logic signed [15:0]    samp_r;
  logic [BinBits-1:0]    k_r;
  logic [WinCntW-1:0]    wpos_r;
  logic [WinBits-1:0]    pos_r;
  logic                  started_r;
  logic [BinBits-1:0]    mbin_r;
  logic [COUNT_BITS-1:0] mcnt_r;
  logic signed [23:0]    ema_r;
  logic                  acc_r;
  logic [BinCntW-1:0]    scan_r;
  logic [BinBits-1:0]    best_r;
  logic [COUNT_BITS-1:0] bestc_r;
  logic [BinBits-1:0]    oldb_r;
  logic                  oldv_r;
  logic signed [23:0]    modev_r;
  logic [47:0]           idx_r;
  logic                  out_valid_r;

  // Count RAM and window RAM (bin index plus valid bit).
  logic                  cnt_we, win_we;
  logic [BinBits-1:0]    cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [WinBits-1:0]    win_waddr;
  logic [BinBits:0]      win_wdata, win_rdata;

  swmt_ram #(.Width(COUNT_BITS), .Depth(NUM_BINS)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  swmt_ram #(.Width(BinBits + 1), .Depth(WINDOW_DEPTH)) u_win (
    .clk, .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
    .raddr(pos_r), .rdata(win_rdata)
  );

  logic in_range;
  assign in_range = (in_sample >= range_min_r) && (in_sample <= range_max_r) &&
                    (nbins != '0);
  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == ClrW'(ClrMax - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid && in_ready) state_nxt = in_range ? ST_MAP : ST_OUT;
      ST_MAP:   state_nxt = (wlen != '0) ? ST_WREAD : ST_NEWRD;
      ST_WREAD: state_nxt = ST_OLD;
      ST_OLD:   state_nxt = ST_DEC;
      ST_DEC: begin
        if (oldv_r && (oldb_r == mbin_r))
          state_nxt = ST_SCAN;
        else
          state_nxt = ST_NEWRD;
      end
      ST_SCAN:  if (scan_r == nbins) state_nxt = ST_NEWRD;
      ST_NEWRD: state_nxt = ST_NEW;
      ST_NEW:   state_nxt = ST_MODEV;
      ST_MODEV: state_nxt = ST_EMA;
      ST_EMA:   state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // RAM control. The leaving entry is read in ST_WREAD, its bin count is read
  // in ST_OLD and decremented in ST_DEC, so the scan and the new-bin read
  // always see the written count.
  logic [COUNT_BITS-1:0] scan_val, inc_val;
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = k_r;
    cnt_wdata = cnt_rdata;
    cnt_raddr = k_r;
    win_we    = 1'b0;
    win_waddr = pos_r;
    win_wdata = {1'b1, k_r};
    scan_val  = cnt_rdata;
    inc_val   = (cnt_rdata < CountMax) ? cnt_rdata + 1'b1 : cnt_rdata;
    case (state_r)
      ST_CLEAR: begin
        cnt_we    = (32'(clr_r) < NUM_BINS);
        cnt_waddr = clr_r[BinBits-1:0];
        cnt_wdata = '0;
        win_we    = (32'(clr_r) < WINDOW_DEPTH);
        win_waddr = clr_r[WinBits-1:0];
        win_wdata = '0;
      end
      ST_OLD: begin
        win_we    = 1'b1;
        cnt_raddr = win_rdata[BinBits-1:0];
      end
      ST_DEC: begin
        cnt_we    = oldv_r && (cnt_rdata != '0);
        cnt_waddr = oldb_r;
        cnt_wdata = cnt_rdata - 1'b1;
      end
      ST_SCAN: cnt_raddr = scan_r[BinBits-1:0];
      ST_NEW: begin
        cnt_we    = 1'b1;
        cnt_wdata = inc_val;
      end
      default: ;
    endcase
  end

  // Products for binning, mode value and EMA.
  logic [15:0]        off;
  logic signed [47:0] mv_full, diff, prod;
  logic signed [47:0] ema_new;
  always_comb begin
    off     = in_sample - range_min_r;
    mv_full = 48'(range_min_r) * 48'sd256 + $signed(48'(mbin_r)) *
              $signed(48'(bin_width_r));
    diff    = 48'(modev_r) - 48'(ema_r);
    prod    = $signed({31'd0, alpha_eff}) * diff;
    ema_new = 48'(ema_r) + ((prod + 48'sd32768) >>> 16);
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wpos_r      <= '0;
      started_r   <= 1'b0;
      mbin_r      <= '0;
      mcnt_r      <= '0;
      ema_r       <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          samp_r <= in_sample;
          acc_r  <= in_range;
        end
        ST_MAP: begin
          if (bin_width_r == '0) k_r <= '0;
          else if (idx_r >= 48'(nbins)) k_r <= BinBits'(nbins - 1'b1);
          else k_r <= idx_r[BinBits-1:0];
          if (!started_r) begin
            started_r <= 1'b1;
            ema_r     <= 24'(samp_r) <<< 8;
          end
          pos_r <= (wpos_r < wlen) ? wpos_r[WinBits-1:0] : '0;
        end
        ST_WREAD: ;
        ST_OLD: begin
          oldb_r    <= win_rdata[BinBits-1:0];
          oldv_r    <= win_rdata[BinBits];
          wpos_r    <= ((WinCntW'(pos_r) + 1'b1) >= wlen) ? '0
                                                           : WinCntW'(pos_r) + 1'b1;
          scan_r    <= '0;
          bestc_r   <= '0;
          best_r    <= '0;
        end
        ST_SCAN: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r != '0 && scan_val >= bestc_r) begin
            bestc_r <= scan_val;
            best_r  <= BinBits'(scan_r - 1'b1);
          end
          if (scan_r == nbins) begin
            if (scan_val >= bestc_r) begin
              mbin_r <= BinBits'(scan_r - 1'b1);
              mcnt_r <= scan_val;
            end else begin
              mbin_r <= best_r;
              mcnt_r <= bestc_r;
            end
          end
        end
        ST_NEW: begin
          if (inc_val >= mcnt_r) begin
            mcnt_r <= inc_val;
            mbin_r <= k_r;
          end
        end
        ST_MODEV: modev_r <= sat24(mv_full);
        ST_EMA:   ema_r   <= sat24(ema_new);
        ST_OUT: begin
          out_valid_r        <= 1'b1;
          out_smoothed_value <= ema_r;
          out_mode_bin       <= 6'(mbin_r);
          out_mode_count     <= 16'(mcnt_r);
          out_accepted       <= acc_r;
        end
        default: ;
      endcase
    end
  end

  // Bin index product of the input word, registered ahead of ST_MAP.
  always_ff @(posedge clk) begin
    idx_r <= (48'(off) * 48'(bin_scale_r)) >> 16;
  end

endmodule

`default_nettype wire

### rtl/swmt_checker.sv
//------------------------------------------------------------------------------
// swmt_checker
// Port-level checks of the mode tracker, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module swmt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  out_mode_bin,
  input wire logic        out_accepted
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mode_bin))
    else $error("result changed while stalled");

  // No new word is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready with pending result");

  // An accepted word does not produce a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

  // A valid result carries known fields.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_mode_bin, out_accepted}))
    else $error("unknown result field");

endmodule

bind sliding_window_mode_tracker_core swmt_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_mode_bin, .out_accepted
);

`default_nettype wire
